FILE: hdl/ehr_pkg.sv
// shared types and constants for the homography event remap
`default_nettype none
package ehr_pkg;
   localparam int SENSOR_COLS_DEF = 304;
   localparam int SENSOR_ROWS_DEF = 240;
   localparam int COEF_BITS_DEF   = 20;
   localparam int REG_BITS        = 60;
   localparam int SHORT_BITS      = 13;
   localparam int CSR_IDX_BITS    = 3;
   localparam int QUO_BITS        = 14;
   localparam int COORD_BITS      = 13;
   localparam logic [SHORT_BITS-1:0] CANVAS_MAX = 13'd4096;
   localparam logic [REG_BITS-1:0] ROW0_RESET = 60'd1024;
   localparam logic [REG_BITS-1:0] ROW1_RESET = 60'd1 << 30;
   localparam logic [REG_BITS-1:0] ROW2_RESET = 60'd1 << 50;
   localparam logic [SHORT_BITS-1:0] COLS_RESET = 13'd304;
   localparam logic [SHORT_BITS-1:0] ROWS_RESET = 13'd240;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_OFFX   = 3'd3,
      CSR_OFFY   = 3'd4,
      CSR_COLS   = 3'd5,
      CSR_ROWS   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [8:0] event_x;
      logic [7:0] event_y;
   } req_type;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic        drawn;
   } rsp_type;
endpackage
`default_nettype wire

FILE: hdl/ehr_div.sv
// pipelined restoring divider lane with floor rounding and range flag
`default_nettype none
module ehr_div #(
   parameter int A_BITS = ehr_pkg::COEF_BITS_DEF + 15,
   parameter int Q_BITS = ehr_pkg::QUO_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [A_BITS-1:0] num,
   input  wire logic signed [A_BITS-1:0] den,
   output logic                          out_valid,
   output logic signed [Q_BITS+1:0]      quo,
   output logic                          ok
);
   localparam int RW = A_BITS + Q_BITS;

   logic [A_BITS-1:0] rem_ff  [Q_BITS+1];
   logic [A_BITS-1:0] dv_ff   [Q_BITS+1];
   logic [Q_BITS-1:0] q_ff    [Q_BITS+1];
   logic              neg_ff  [Q_BITS+1];
   logic              ok_ff   [Q_BITS+1];
   logic              v_ff    [Q_BITS+1];
   logic [A_BITS-1:0] abs_n, abs_d;
   logic signed [Q_BITS+1:0] quo_ff, quo_in, qs;
   logic out_valid_ff, ok_out_ff;

   assign abs_n = num[A_BITS-1] ? (~num + 1'b1) : num;
   assign abs_d = den[A_BITS-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= abs_n;
         dv_ff[0]  <= abs_d;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[A_BITS-1] ^ den[A_BITS-1];
         // quotient must fit in Q_BITS, else far off canvas
         ok_ff[0]  <= (abs_d != '0) && ((abs_n >> Q_BITS) < abs_d);
      end
   end

   for (genvar k = 0; k < Q_BITS; k++) begin : g_step
      logic [RW-1:0] trial;
      logic          take;
      assign trial = RW'(dv_ff[k]) << (Q_BITS - 1 - k);
      assign take  = RW'(rem_ff[k]) >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            rem_ff[k+1] <= take ? A_BITS'(RW'(rem_ff[k]) - trial) : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (take ? (Q_BITS'(1) << (Q_BITS - 1 - k)) : '0);
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ok_ff[k+1]  <= ok_ff[k];
         end
      end
   end

   assign qs = (Q_BITS + 2)'(q_ff[Q_BITS]);
   always_comb begin
      if (!neg_ff[Q_BITS]) begin
         quo_in = qs;
      end else if (rem_ff[Q_BITS] != '0) begin
         // -q - 1 rounds an inexact negative quotient down
         quo_in = ~qs;
      end else begin
         quo_in = -qs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[Q_BITS];
      end
      if (en) begin
         quo_ff    <= quo_in;
         ok_out_ff <= ok_ff[Q_BITS];
      end
   end

   assign out_valid = out_valid_ff;
   assign quo       = quo_ff;
   assign ok        = ok_out_ff;
endmodule
`default_nettype wire

FILE: hdl/ehr_mac.sv
// mirror, six products and three sums of the homography row vector
`default_nettype none
module ehr_mac #(
   parameter int SENSOR_COLS = ehr_pkg::SENSOR_COLS_DEF,
   parameter int SENSOR_ROWS = ehr_pkg::SENSOR_ROWS_DEF,
   parameter int COEF_BITS   = ehr_pkg::COEF_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire ehr_pkg::req_type                  in_data,
   input  wire logic [ehr_pkg::REG_BITS-1:0]      row0,
   input  wire logic [ehr_pkg::REG_BITS-1:0]      row1,
   input  wire logic [ehr_pkg::REG_BITS-1:0]      row2,
   output logic                                   out_valid,
   output logic signed [COEF_BITS+14:0]           sum [3]
);
   localparam int CB = COEF_BITS;
   localparam int XB = ehr_pkg::COORD_BITS;
   localparam int PB = CB + XB;
   localparam int AB = CB + 15;
   localparam logic signed [XB-1:0] XTOP = XB'(SENSOR_COLS - 1);
   localparam logic signed [XB-1:0] YTOP = XB'(SENSOR_ROWS - 1);

   logic [3*CB-1:0] r0w, r1w, r2w;
   logic signed [XB-1:0] xm_ff, ym_ff;
   logic signed [PB-1:0] px_ff [3];
   logic signed [PB-1:0] py_ff [3];
   logic signed [CB-1:0] c2_ff [3];
   logic signed [AB-1:0] sum_ff [3];
   logic v1_ff, v2_ff, v3_ff;

   // bits above the register read as zero
   assign r0w = (3*CB)'({{(3*CB){1'b0}}, row0});
   assign r1w = (3*CB)'({{(3*CB){1'b0}}, row1});
   assign r2w = (3*CB)'({{(3*CB){1'b0}}, row2});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         xm_ff <= XTOP - $signed(XB'(in_data.event_x));
         ym_ff <= YTOP - $signed(XB'(in_data.event_y));
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [PB-1:0] xe, ye, cx, cy;
      logic signed [AB-1:0] ax, ay, ac;
      assign xe = xm_ff;
      assign ye = ym_ff;
      assign cx = $signed(r0w[j*CB +: CB]);
      assign cy = $signed(r1w[j*CB +: CB]);
      assign ax = px_ff[j];
      assign ay = py_ff[j];
      assign ac = c2_ff[j];
      always_ff @(posedge clock) begin
         if (en) begin
            px_ff[j]  <= xe * cx;
            py_ff[j]  <= ye * cy;
            c2_ff[j]  <= $signed(r2w[j*CB +: CB]);
            sum_ff[j] <= ax + ay + ac;
         end
      end
      assign sum[j] = sum_ff[j];
   end

   assign out_valid = v3_ff;
endmodule
`default_nettype wire

FILE: hdl/event_homography_remap.sv
// top level: event address remap through a 3x3 projective homography
// path: accepted request beat through the mac stages, divider lanes and response register to response beat
// throughput: one beat per cycle; mac stages, two 14-step divider lanes, range check
// a response waiting under rsp_stall halts the whole pipeline in place
// synchronous reset clears all valid bits and loads the identity matrix, 304x240 canvas
`default_nettype none
module event_homography_remap #(
   parameter int SENSOR_COLS = ehr_pkg::SENSOR_COLS_DEF,
   parameter int SENSOR_ROWS = ehr_pkg::SENSOR_ROWS_DEF,
   parameter int COEF_BITS   = ehr_pkg::COEF_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ehr_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ehr_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ehr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [ehr_pkg::REG_BITS-1:0]        csr_data
);
   localparam int AB = COEF_BITS + 15;
   localparam int QB = ehr_pkg::QUO_BITS;
   localparam int SB = ehr_pkg::SHORT_BITS;
   localparam int PW = QB + 3;

   logic [ehr_pkg::REG_BITS-1:0] row0_ff, row1_ff, row2_ff;
   logic [SB-1:0] offx_ff, offy_ff, cols_ff, rows_ff;
   logic [SB-1:0] limx, limy;
   logic en, mac_valid, d0_valid, d1_valid, d0_ok, d1_ok;
   logic signed [AB-1:0] sum [3];
   logic signed [QB+1:0] q0, q1;
   logic signed [PW-1:0] px, py;
   logic on_canvas;
   logic rsp_valid_ff;
   ehr_pkg::rsp_type rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= ehr_pkg::ROW0_RESET;
         row1_ff <= ehr_pkg::ROW1_RESET;
         row2_ff <= ehr_pkg::ROW2_RESET;
         offx_ff <= '0;
         offy_ff <= '0;
         cols_ff <= ehr_pkg::COLS_RESET;
         rows_ff <= ehr_pkg::ROWS_RESET;
      end else if (csr_valid) begin
         case (ehr_pkg::csr_index_type'(csr_index))
            ehr_pkg::CSR_ROW0: row0_ff <= csr_data;
            ehr_pkg::CSR_ROW1: row1_ff <= csr_data;
            ehr_pkg::CSR_ROW2: row2_ff <= csr_data;
            ehr_pkg::CSR_OFFX: offx_ff <= csr_data[SB-1:0];
            ehr_pkg::CSR_OFFY: offy_ff <= csr_data[SB-1:0];
            ehr_pkg::CSR_COLS: cols_ff <= csr_data[SB-1:0];
            ehr_pkg::CSR_ROWS: rows_ff <= csr_data[SB-1:0];
            default: ;
         endcase
      end
   end

   ehr_mac #(
      .SENSOR_COLS (SENSOR_COLS),
      .SENSOR_ROWS (SENSOR_ROWS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .row0      (row0_ff),
      .row1      (row1_ff),
      .row2      (row2_ff),
      .out_valid (mac_valid),
      .sum       (sum)
   );

   ehr_div #(.A_BITS(AB), .Q_BITS(QB)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mac_valid),
      .num       (sum[0]),
      .den       (sum[2]),
      .out_valid (d0_valid),
      .quo       (q0),
      .ok        (d0_ok)
   );

   ehr_div #(.A_BITS(AB), .Q_BITS(QB)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mac_valid),
      .num       (sum[1]),
      .den       (sum[2]),
      .out_valid (d1_valid),
      .quo       (q1),
      .ok        (d1_ok)
   );

   assign limx = (cols_ff > ehr_pkg::CANVAS_MAX) ? ehr_pkg::CANVAS_MAX : cols_ff;
   assign limy = (rows_ff > ehr_pkg::CANVAS_MAX) ? ehr_pkg::CANVAS_MAX : rows_ff;
   assign px = PW'(q0) + PW'($signed(offx_ff)) + PW'(1);
   assign py = PW'(q1) + PW'($signed(offy_ff)) + PW'(1);
   assign on_canvas = d0_ok && d1_ok && !px[PW-1] && !py[PW-1]
                   && (px < $signed(PW'(limx))) && (py < $signed(PW'(limy)));

   always_comb begin
      rsp_in = '0;
      if (on_canvas) begin
         rsp_in.pixel_x = px[11:0];
         rsp_in.pixel_y = py[11:0];
         rsp_in.drawn   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d0_valid && d1_valid;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: tb/event_homography_remap_checker.sv
// scoreboard for the homography event remap: predicts each pixel and compares response beats
`timescale 1ns / 1ps
module event_homography_remap_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire ehr_pkg::req_type                   req_data,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire ehr_pkg::rsp_type                   rsp_data,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [ehr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ehr_pkg::REG_BITS-1:0]       csr_data,
   output int                                      mismatches,
   output int                                      outstanding,
   output int                                      pixels_seen
);
   localparam int CB = ehr_pkg::COEF_BITS_DEF;
   localparam int RB = ehr_pkg::REG_BITS;
   localparam int SB = ehr_pkg::SHORT_BITS;

   logic [RB-1:0] row0, row1, row2;
   logic [SB-1:0] off_x, off_y, cols, rows;
   ehr_pkg::rsp_type expected_pixels[$];

   function automatic longint coef(logic [RB-1:0] row, int slot);
      logic [CB-1:0] f;
      f = row[slot*CB +: CB];
      return longint'($signed(f));
   endfunction

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic longint canvas_edge(logic [SB-1:0] c);
      return (c > ehr_pkg::CANVAS_MAX) ? longint'(ehr_pkg::CANVAS_MAX) : longint'(c);
   endfunction

   function automatic ehr_pkg::rsp_type remap_event(ehr_pkg::req_type ev);
      longint xm, ym, a0, a1, a2, px, py;
      ehr_pkg::rsp_type r;
      xm = longint'(ehr_pkg::SENSOR_COLS_DEF - 1) - longint'(ev.event_x);
      ym = longint'(ehr_pkg::SENSOR_ROWS_DEF - 1) - longint'(ev.event_y);
      a0 = xm * coef(row0, 0) + ym * coef(row1, 0) + coef(row2, 0);
      a1 = xm * coef(row0, 1) + ym * coef(row1, 1) + coef(row2, 1);
      a2 = xm * coef(row0, 2) + ym * coef(row1, 2) + coef(row2, 2);
      r = '0;
      if (a2 != 0) begin
         px = floor_quot(a0, a2) + longint'($signed(off_x)) + 1;
         py = floor_quot(a1, a2) + longint'($signed(off_y)) + 1;
         if (px >= 0 && px < canvas_edge(cols) && py >= 0 && py < canvas_edge(rows)) begin
            r.pixel_x = px[11:0];
            r.pixel_y = py[11:0];
            r.drawn   = 1'b1;
         end
      end
      return r;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      pixels_seen = 0;
   end

   always @(posedge clock) begin
      ehr_pkg::rsp_type want;
      if (reset) begin
         row0  = ehr_pkg::ROW0_RESET;
         row1  = ehr_pkg::ROW1_RESET;
         row2  = ehr_pkg::ROW2_RESET;
         off_x = '0;
         off_y = '0;
         cols  = ehr_pkg::COLS_RESET;
         rows  = ehr_pkg::ROWS_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected response beat %p", $realtime, rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                   rsp_data.drawn !== want.drawn) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] pixel mismatch: expected x=%0d y=%0d drawn=%0b,",
                               " got x=%0d y=%0d drawn=%0b"},
                              $realtime, want.pixel_x, want.pixel_y, want.drawn,
                              rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.drawn);
               end
            end
         end
         // requests are predicted with the settings in force before this edge's write
         if (req_valid && !req_stall)
            expected_pixels.insert(expected_pixels.size(), remap_event(req_data));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ehr_pkg::CSR_ROW0: row0  = csr_data;
               ehr_pkg::CSR_ROW1: row1  = csr_data;
               ehr_pkg::CSR_ROW2: row2  = csr_data;
               ehr_pkg::CSR_OFFX: off_x = csr_data[SB-1:0];
               ehr_pkg::CSR_OFFY: off_y = csr_data[SB-1:0];
               ehr_pkg::CSR_COLS: cols  = csr_data[SB-1:0];
               ehr_pkg::CSR_ROWS: rows  = csr_data[SB-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_pixels.size();
   end
endmodule

FILE: tb/event_homography_remap_tb.sv
// top of the homography event remap testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module event_homography_remap_tb;
   localparam int IB = ehr_pkg::CSR_IDX_BITS;
   localparam int RB = ehr_pkg::REG_BITS;
   localparam logic [IB-1:0] CSR_UNUSED = 3'd7;
   localparam int LATENCY = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ehr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ehr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IB-1:0] csr_index = '0;
   logic [RB-1:0] csr_data = '0;

   int mismatches, outstanding, pixels_seen;
   int events_sent = 0;
   int csr_writes = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   bit hold = 1'b0;

   event_homography_remap DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   event_homography_remap_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches, .outstanding, .pixels_seen
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock)
      rsp_stall <= hold || (!steady && $urandom_range(99) < 14);

   initial begin
      wait (hold_request);
      hold = 1'b1;
      repeat (150) @(negedge clock);
      hold = 1'b0;
   end

   function automatic logic [RB-1:0] pack_row(int c0, int c1, int c2);
      logic [19:0] f0, f1, f2;
      f0 = c0[19:0];
      f1 = c1[19:0];
      f2 = c2[19:0];
      return {f2, f1, f0};
   endfunction

   function automatic int spread(int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   task automatic write_csr(logic [IB-1:0] idx, logic [RB-1:0] value);
      wait (outstanding == 0);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   task automatic send_event(int x, int y);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.event_x = x[8:0];
      req_data.event_y = y[7:0];
      do @(posedge clock); while (req_stall);
      events_sent++;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 1'b0;
      wait (outstanding == 0);
   endtask

   task automatic random_setup(bit plausible);
      logic [RB-1:0] r0, r1, r2;
      if (plausible) begin
         r0 = pack_row(1024 + spread(96), spread(48), spread(3));
         r1 = pack_row(spread(48), 1024 + spread(96), spread(3));
         r2 = pack_row(spread(40000), spread(40000), 1024 + spread(200));
         write_csr(ehr_pkg::CSR_OFFX, RB'(13'($signed(spread(60)))));
         write_csr(ehr_pkg::CSR_OFFY, RB'(13'($signed(spread(60)))));
         write_csr(ehr_pkg::CSR_COLS, RB'(($urandom_range(9) == 0) ? 13'd8191
                                          : 13'($urandom_range(200, 4096))));
         write_csr(ehr_pkg::CSR_ROWS, RB'(($urandom_range(9) == 0) ? 13'd8191
                                          : 13'($urandom_range(150, 4096))));
      end else begin
         r0 = RB'({$urandom, $urandom});
         r1 = RB'({$urandom, $urandom});
         r2 = RB'({$urandom, $urandom});
         write_csr(ehr_pkg::CSR_OFFX, RB'(13'($urandom)));
         write_csr(ehr_pkg::CSR_OFFY, RB'(13'($urandom)));
         write_csr(ehr_pkg::CSR_COLS, RB'(13'($urandom)));
         write_csr(ehr_pkg::CSR_ROWS, RB'(13'($urandom)));
      end
      write_csr(ehr_pkg::CSR_ROW0, r0);
      write_csr(ehr_pkg::CSR_ROW1, r1);
      write_csr(ehr_pkg::CSR_ROW2, r2);
      write_csr(CSR_UNUSED, RB'({$urandom, $urandom}));
   endtask

   initial begin
      int x, y;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity after reset: mirrored addresses, sensor edges and beyond
      send_event(0, 0);
      send_event(303, 239);
      send_event(303, 0);
      send_event(0, 239);
      send_event(304, 240);
      send_event(511, 255);
      send_event(150, 100);
      send_event(302, 238);
      end_burst();

      // zero divisor
      write_csr(ehr_pkg::CSR_ROW2, '0);
      send_event(10, 20);
      send_event(303, 239);
      end_burst();
      write_csr(ehr_pkg::CSR_ROW2, ehr_pkg::ROW2_RESET);

      // offsets at their extremes
      write_csr(ehr_pkg::CSR_OFFX, RB'(13'h1000));
      write_csr(ehr_pkg::CSR_OFFY, RB'(13'h0fff));
      send_event(0, 0);
      send_event(303, 239);
      end_burst();

      // empty canvas, then oversized canvas
      write_csr(ehr_pkg::CSR_OFFX, '0);
      write_csr(ehr_pkg::CSR_OFFY, '0);
      write_csr(ehr_pkg::CSR_COLS, '0);
      send_event(200, 100);
      end_burst();
      write_csr(ehr_pkg::CSR_COLS, RB'(13'h1fff));
      write_csr(ehr_pkg::CSR_ROWS, RB'(13'h1fff));
      write_csr(ehr_pkg::CSR_OFFX, RB'(13'd4095));
      write_csr(ehr_pkg::CSR_OFFY, RB'(13'd3000));
      send_event(303, 239);
      send_event(0, 0);
      end_burst();

      // every coefficient at minus one
      write_csr(ehr_pkg::CSR_ROW0, '1);
      write_csr(ehr_pkg::CSR_ROW1, '1);
      write_csr(ehr_pkg::CSR_ROW2, '1);
      send_event(100, 50);
      send_event(511, 255);
      end_burst();

      for (int phase = 0; phase < 6; phase++) begin
         random_setup(phase != 1 && phase != 5);
         for (int n = 0; n < 75; n++) begin
            steady = (phase == 2 && n < 60);
            if (phase == 3 && n == 10) hold_request = 1'b1;
            if (phase == 4 && n == 40) end_burst();
            x = ($urandom_range(99) < 85) ? $urandom_range(303) : $urandom_range(304, 511);
            y = ($urandom_range(99) < 85) ? $urandom_range(239) : $urandom_range(240, 255);
            send_event(x, y);
         end
         end_burst();
      end
      steady = 1'b0;

      repeat (LATENCY * 4) @(posedge clock);
      $display("covered %0d events, %0d responses, %0d register writes over 6 random setups",
               events_sent, pixels_seen, csr_writes);
      $display("directed: sensor edges, zero divisor, off and oversized canvas, offset extremes");
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
